[design/rfs_pkg.sv]
package rfs_pkg;

  localparam int VAL_W     = 31;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int NB_W      = 5;

  localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd65521;
  localparam logic [LEN_W-1:0] LENGTH_RESET  = 9'd16;
  localparam logic [VAL_W-1:0] RADIX         = 31'd256;

  // multiplier bit counts for the serial unit
  localparam logic [NB_W-1:0] NB_FULL   = 5'd31;
  localparam logic [NB_W-1:0] NB_BYTE   = 5'd8;
  localparam logic [NB_W-1:0] NB_RADIX  = 5'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS       = 2'd0,
    REG_WINDOW_LENGTH = 2'd1,
    REG_TARGET        = 2'd2,
    REG_INVERSE       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_stream;
  } in_word_t;

  typedef struct packed {
    logic             window_ready;
    logic [VAL_W-1:0] window_value;
    logic             window_match;
    logic             found_any;
  } out_word_t;

  // request to the modular multiplier: result = multiplier * addend mod p,
  // addend already below p, multiplier taken raw
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] multiplier;
    logic [NB_W-1:0]  nbits;
    logic [VAL_W-1:0] addend;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] result;
  } mm_rsp_t;

endpackage

[design/rfs_modmul.sv]
// Serial modular multiplier, one multiplier bit per cycle, MSB first.
module rfs_modmul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rfs_pkg::mm_req_t                req,
  input  logic [rfs_pkg::VAL_W-1:0]       modulus,
  output rfs_pkg::mm_rsp_t                rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [rfs_pkg::NB_W-1:0]      cnt_r;
  logic [rfs_pkg::VAL_W-1:0]     mult_r;
  logic [rfs_pkg::VAL_W-1:0]     addend_r;
  logic [rfs_pkg::VAL_W-1:0]     acc_r;

  logic [rfs_pkg::VAL_W:0] p_ext;
  logic [rfs_pkg::VAL_W:0] dbl;
  logic [rfs_pkg::VAL_W:0] dbl_red;
  logic [rfs_pkg::VAL_W:0] sum;
  logic [rfs_pkg::VAL_W:0] sum_red;

  always_comb begin
    p_ext   = {1'b0, modulus};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
    sum     = dbl_red + (mult_r[rfs_pkg::VAL_W-1] ? {1'b0, addend_r} : '0);
    sum_red = (sum >= p_ext) ? sum - p_ext : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= req.nbits;
        mult_r   <= req.multiplier << (rfs_pkg::NB_FULL - req.nbits);
        addend_r <= req.addend;
        acc_r    <= '0;
      end else if (busy_r) begin
        acc_r  <= sum_red[rfs_pkg::VAL_W-1:0];
        mult_r <= mult_r << 1;
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

[design/rfs_window_mem.sv]
// Byte store of the sliding window, registered read.
module rfs_window_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [rfs_pkg::BYTE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [rfs_pkg::BYTE_W-1:0]  rd_data
);

  logic [rfs_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [rfs_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/rolling_fingerprint_search.sv]
// Channel   Ports                               Direction  Moves
// input     in_valid / in_stall / in_word       in         one stream byte per word
// result    out_valid / out_stall / out_word    out        one fingerprint result per word
// config    cfg_we / cfg_index / cfg_data       in         register write, no read-back
//
// Work: set by the serial modular multiplier (one multiplier bit a cycle), used four
//   times per word while the window fills and five times per word once it rolls.
//   One word is in work at a time; the next is taken once it is finished.
// Reset: rst_n synchronous, active low; config back to defaults, stream restarted.
//   The window store is not cleared.
// Stalls: a finished result sits in the output register; the next word is taken and
//   worked while it waits, and only its write-out holds until the register is free.
module rolling_fingerprint_search #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rfs_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rfs_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [rfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfs_pkg::VAL_W-1:0]         cfg_data
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [31:0] MAXW = 32'(MAX_WINDOW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_F_WEIGHT,   // w = fill_weight mod p
    ST_F_BYTE,     // byte * w
    ST_F_RUN,      // running value mod p, then add
    ST_F_NEXTW,    // fill_weight = w * 256
    ST_R_RUN,      // running value mod p
    ST_R_OLD,      // oldest byte mod p, then subtract
    ST_R_INV,      // times inverse of 256
    ST_R_TOP,      // top weight mod p
    ST_R_BYTE,     // byte * top weight, then add
    ST_FINISH
  } state_t;

  // config
  logic [rfs_pkg::VAL_W-1:0] modulus_r;
  logic [rfs_pkg::LEN_W-1:0] wlen_r;
  logic [rfs_pkg::VAL_W-1:0] target_r;
  logic [rfs_pkg::VAL_W-1:0] inverse_r;

  // stream state
  logic [AW-1:0]             wi_r;
  logic [rfs_pkg::LEN_W-1:0] fc_r;
  logic [rfs_pkg::VAL_W-1:0] rv_r;
  logic [rfs_pkg::VAL_W-1:0] fw_r;
  logic [rfs_pkg::VAL_W-1:0] tw_r;
  logic                      found_r;

  // word in work
  state_t                     state_r;
  logic                       launched_r;
  logic [rfs_pkg::BYTE_W-1:0] byte_r;
  logic [rfs_pkg::VAL_W-1:0]  w_r;
  logic [rfs_pkg::VAL_W-1:0]  prod_r;
  logic [rfs_pkg::VAL_W-1:0]  tmp_r;
  logic [rfs_pkg::VAL_W-1:0]  v_r;

  logic                       out_valid_r;
  rfs_pkg::out_word_t         out_word_r;

  logic [rfs_pkg::VAL_W-1:0]  p_eff;
  logic [rfs_pkg::VAL_W-1:0]  one_red;
  logic [rfs_pkg::LEN_W-1:0]  k_eff;
  logic [31:0]                old_pos;
  logic [AW-1:0]              wi_next;
  logic                       accept;
  logic                       op_state;
  logic                       can_finish;
  logic                       ready_now;
  logic                       match_now;

  rfs_pkg::mm_req_t           mm_req;
  rfs_pkg::mm_rsp_t           mm_rsp;
  logic [rfs_pkg::BYTE_W-1:0] old_byte;

  function automatic logic [rfs_pkg::VAL_W-1:0] add_mod(
    input logic [rfs_pkg::VAL_W-1:0] a,
    input logic [rfs_pkg::VAL_W-1:0] b,
    input logic [rfs_pkg::VAL_W-1:0] p
  );
    logic [rfs_pkg::VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[rfs_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [rfs_pkg::VAL_W-1:0] sub_mod(
    input logic [rfs_pkg::VAL_W-1:0] a,
    input logic [rfs_pkg::VAL_W-1:0] b,
    input logic [rfs_pkg::VAL_W-1:0] p
  );
    logic [rfs_pkg::VAL_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, p} - {1'b0, b};
    end
    return s[rfs_pkg::VAL_W-1:0];
  endfunction

  // zero modulus acts as one; zero length as one, long lengths clamp to the store
  always_comb begin
    p_eff   = (modulus_r == '0) ? 31'd1 : modulus_r;
    one_red = (p_eff == 31'd1) ? 31'd0 : 31'd1;
    if (wlen_r == '0) begin
      k_eff = 9'd1;
    end else if (32'(wlen_r) > MAXW) begin
      k_eff = MAXW[rfs_pkg::LEN_W-1:0];
    end else begin
      k_eff = wlen_r;
    end
  end

  // oldest byte sits k places behind the write pointer
  always_comb begin
    if (32'(wi_r) >= 32'(k_eff)) begin
      old_pos = 32'(wi_r) - 32'(k_eff);
    end else begin
      old_pos = 32'(wi_r) + MAXW - 32'(k_eff);
    end
    wi_next = (32'(wi_r) == MAXW - 32'd1) ? '0 : wi_r + AW'(1);
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign can_finish = !out_valid_r || !out_stall;
  assign ready_now  = (fc_r >= k_eff);
  assign match_now  = ready_now && (rv_r == target_r);

  // operand selection for the multiplier, at most one operation per state
  always_comb begin
    op_state          = 1'b1;
    mm_req.multiplier = '0;
    mm_req.nbits      = rfs_pkg::NB_FULL;
    mm_req.addend     = one_red;
    unique case (state_r)
      ST_F_WEIGHT: begin
        mm_req.multiplier = fw_r;
      end
      ST_F_BYTE: begin
        mm_req.multiplier = {23'd0, byte_r};
        mm_req.nbits      = rfs_pkg::NB_BYTE;
        mm_req.addend     = w_r;
      end
      ST_F_RUN, ST_R_RUN: begin
        mm_req.multiplier = rv_r;
      end
      ST_F_NEXTW: begin
        mm_req.multiplier = rfs_pkg::RADIX;
        mm_req.nbits      = rfs_pkg::NB_RADIX;
        mm_req.addend     = w_r;
      end
      ST_R_OLD: begin
        mm_req.multiplier = {23'd0, old_byte};
        mm_req.nbits      = rfs_pkg::NB_BYTE;
      end
      ST_R_INV: begin
        mm_req.multiplier = inverse_r;
        mm_req.addend     = v_r;
      end
      ST_R_TOP: begin
        mm_req.multiplier = tw_r;
      end
      ST_R_BYTE: begin
        mm_req.multiplier = {23'd0, byte_r};
        mm_req.nbits      = rfs_pkg::NB_BYTE;
        mm_req.addend     = w_r;
      end
      ST_IDLE, ST_DECIDE, ST_FINISH: begin
        op_state = 1'b0;
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    mm_req.start = op_state && !launched_r;
  end

  rfs_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .modulus (p_eff),
    .rsp     (mm_rsp)
  );

  // read of the oldest byte issued while deciding; held until the next read
  rfs_window_mem #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   ((state_r == ST_FINISH) && can_finish),
    .wr_addr (wi_r),
    .wr_data (byte_r),
    .rd_en   (state_r == ST_DECIDE),
    .rd_addr (old_pos[AW-1:0]),
    .rd_data (old_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= rfs_pkg::MODULUS_RESET;
      wlen_r      <= rfs_pkg::LENGTH_RESET;
      target_r    <= '0;
      inverse_r   <= '0;
      wi_r        <= '0;
      fc_r        <= '0;
      rv_r        <= '0;
      fw_r        <= 31'd1;
      tw_r        <= '0;
      found_r     <= 1'b0;
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (rfs_pkg::cfg_reg_t'(cfg_index))
          rfs_pkg::REG_MODULUS:       modulus_r <= cfg_data;
          rfs_pkg::REG_WINDOW_LENGTH: wlen_r    <= cfg_data[rfs_pkg::LEN_W-1:0];
          rfs_pkg::REG_TARGET:        target_r  <= cfg_data;
          rfs_pkg::REG_INVERSE:       inverse_r <= cfg_data;
          default: ;
        endcase
      end

      // a new word may replace the one leaving in the same cycle
      if ((state_r == ST_FINISH) && can_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (mm_req.start) begin
        launched_r <= 1'b1;
      end else if (mm_rsp.done) begin
        launched_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            byte_r  <= in_word.data_byte;
            state_r <= ST_DECIDE;
            if (in_word.first_of_stream) begin
              wi_r    <= '0;
              fc_r    <= '0;
              rv_r    <= '0;
              fw_r    <= 31'd1;
              tw_r    <= '0;
              found_r <= 1'b0;
            end
          end
        end
        ST_DECIDE: begin
          state_r <= ready_now ? ST_R_RUN : ST_F_WEIGHT;
        end
        ST_F_WEIGHT: begin
          if (mm_rsp.done) begin
            w_r     <= mm_rsp.result;
            state_r <= ST_F_BYTE;
          end
        end
        ST_F_BYTE: begin
          if (mm_rsp.done) begin
            prod_r  <= mm_rsp.result;
            state_r <= ST_F_RUN;
          end
        end
        ST_F_RUN: begin
          if (mm_rsp.done) begin
            rv_r    <= add_mod(mm_rsp.result, prod_r, p_eff);
            state_r <= ST_F_NEXTW;
          end
        end
        ST_F_NEXTW: begin
          if (mm_rsp.done) begin
            fw_r <= mm_rsp.result;
            fc_r <= fc_r + 9'd1;
            // k-th byte: its weight becomes the weight of every new byte
            if (fc_r + 9'd1 == k_eff) begin
              tw_r <= w_r;
            end
            state_r <= ST_FINISH;
          end
        end
        ST_R_RUN: begin
          if (mm_rsp.done) begin
            tmp_r   <= mm_rsp.result;
            state_r <= ST_R_OLD;
          end
        end
        ST_R_OLD: begin
          if (mm_rsp.done) begin
            v_r     <= sub_mod(tmp_r, mm_rsp.result, p_eff);
            state_r <= ST_R_INV;
          end
        end
        ST_R_INV: begin
          if (mm_rsp.done) begin
            v_r     <= mm_rsp.result;
            state_r <= ST_R_TOP;
          end
        end
        ST_R_TOP: begin
          if (mm_rsp.done) begin
            w_r     <= mm_rsp.result;
            state_r <= ST_R_BYTE;
          end
        end
        ST_R_BYTE: begin
          if (mm_rsp.done) begin
            rv_r    <= add_mod(v_r, mm_rsp.result, p_eff);
            fc_r    <= k_eff;
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (can_finish) begin
            wi_r                    <= wi_next;
            out_word_r.window_ready <= ready_now;
            out_word_r.window_value <= ready_now ? rv_r : '0;
            out_word_r.window_match <= match_now;
            out_word_r.found_any    <= found_r || match_now;
            found_r                 <= found_r || match_now;
            state_r                 <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[design/rfs_checker.sv]
module rfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rfs_pkg::in_word_t   in_word,
  input logic                out_valid,
  input logic                out_stall,
  input rfs_pkg::out_word_t  out_word
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a word is in work");

  a_not_ready_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.window_ready |->
      (out_word.window_value == '0) && !out_word.window_match)
    else $error("value or match shown for an unfilled window");

  a_match_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.window_match |-> out_word.found_any)
    else $error("match without found flag");

endmodule

bind rolling_fingerprint_search rfs_checker u_rfs_checker (.*);
